// ===== hdl/emb_pkg.sv =====
// shared types, codes and constants of the emulated memory bus decoder
package emb_pkg;

    // input modes
    localparam logic [2:0] MODE_READ      = 3'd0;
    localparam logic [2:0] MODE_WRITE     = 3'd1;
    localparam logic [2:0] MODE_SET_FRAME = 3'd2;
    localparam logic [2:0] MODE_SET_CYC   = 3'd3;
    localparam logic [2:0] MODE_IRQ_RAISE = 3'd4;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_BAD  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_MAIN_BASE  = 3'd0;
    localparam logic [2:0] CFG_VRAM_BASE  = 3'd1;
    localparam logic [2:0] CFG_AUDIO_BASE = 3'd2;
    localparam logic [2:0] CFG_EEP_BASE   = 3'd3;
    localparam logic [2:0] CFG_GPU_BASE   = 3'd4;
    localparam logic [2:0] CFG_IO_BASE    = 3'd5;
    localparam logic [2:0] CFG_BUDGET     = 3'd6;
    localparam logic [2:0] CFG_VERSION    = 3'd7;

    localparam logic [31:0] MAIN_BASE_RST  = 32'h0000_0000;
    localparam logic [31:0] VRAM_BASE_RST  = 32'h0100_0000;
    localparam logic [31:0] AUDIO_BASE_RST = 32'h0200_0000;
    localparam logic [31:0] EEP_BASE_RST   = 32'h0300_0000;
    localparam logic [31:0] GPU_BASE_RST   = 32'h0400_0000;
    localparam logic [31:0] IO_BASE_RST    = 32'h1000_0000;
    localparam logic [31:0] BUDGET_RST     = 32'h0000_0000;
    localparam logic [31:0] VERSION_RST    = 32'h0000_0001;

    // region codes, in match priority order
    localparam int NUM_RGN = 6;
    localparam logic [2:0] RGN_MAIN  = 3'd0;
    localparam logic [2:0] RGN_VIDEO = 3'd1;
    localparam logic [2:0] RGN_AUDIO = 3'd2;
    localparam logic [2:0] RGN_EEP   = 3'd3;
    localparam logic [2:0] RGN_GPU   = 3'd4;
    localparam logic [2:0] RGN_IO    = 3'd5;

    // default region sizes in bytes
    localparam int MAIN_BYTES_DEF    = 65536;
    localparam int VIDEO_BYTES_DEF   = 16384;
    localparam int AUDIO_BYTES_DEF   = 4096;
    localparam int EEPROM_BYTES_DEF  = 1024;
    localparam int GPU_CMD_BYTES_DEF = 4096;
    localparam int IO_BYTES_DEF      = 4096;

    // offset width covers the largest region, rows are groups of four byte lanes
    localparam int OFF_W  = 24;
    localparam int ROW_AW = OFF_W - 2;
    localparam int LANES  = 4;

    // system register offsets from io_base
    localparam logic [31:0] OFF_FRAME     = 32'h100;
    localparam logic [31:0] OFF_VERSION   = 32'h200;
    localparam logic [31:0] OFF_MAIN_SZ   = 32'h204;
    localparam logic [31:0] OFF_VIDEO_SZ  = 32'h208;
    localparam logic [31:0] OFF_AUDIO_SZ  = 32'h20C;
    localparam logic [31:0] OFF_RANDOM    = 32'h210;
    localparam logic [31:0] OFF_CYCLES    = 32'h214;
    localparam logic [31:0] OFF_CYC_MAX   = 32'h218;
    localparam logic [31:0] OFF_IRQ_PEND  = 32'h300;
    localparam logic [31:0] OFF_IRQ_EN    = 32'h304;
    localparam logic [31:0] OFF_IRQ_ACK   = 32'h308;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    // work kinds handed from front to back
    localparam logic [3:0] K_NOP       = 4'd0;
    localparam logic [3:0] K_MEM_RD    = 4'd1;
    localparam logic [3:0] K_MEM_WR    = 4'd2;
    localparam logic [3:0] K_REG_VAL   = 4'd3;
    localparam logic [3:0] K_REG_FRAME = 4'd4;
    localparam logic [3:0] K_REG_RAND  = 4'd5;
    localparam logic [3:0] K_REG_CYC   = 4'd6;
    localparam logic [3:0] K_REG_IRQ   = 4'd7;
    localparam logic [3:0] K_IRQ_ACK   = 4'd8;
    localparam logic [3:0] K_SET_FRAME = 4'd9;
    localparam logic [3:0] K_SET_CYC   = 4'd10;
    localparam logic [3:0] K_IRQ_RAISE = 4'd11;

    typedef struct packed {
        logic [3:0]       kind;
        logic [2:0]       region;
        logic [1:0]       size;
        logic [OFF_W-1:0] off;
        logic [31:0]      data;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== hdl/emb_front.sv =====
// front end: configuration registers and classification of each bus word
module emb_front #(
    parameter int MAIN_BYTES    = emb_pkg::MAIN_BYTES_DEF,
    parameter int VIDEO_BYTES   = emb_pkg::VIDEO_BYTES_DEF,
    parameter int AUDIO_BYTES   = emb_pkg::AUDIO_BYTES_DEF,
    parameter int EEPROM_BYTES  = emb_pkg::EEPROM_BYTES_DEF,
    parameter int GPU_CMD_BYTES = emb_pkg::GPU_CMD_BYTES_DEF,
    parameter int IO_BYTES      = emb_pkg::IO_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [2:0]          mode,
    input  logic [1:0]          access_size,
    input  logic [31:0]         address,
    input  logic [31:0]         write_data,
    input  logic [31:0]         frame_value,
    input  logic [31:0]         cycles_value,
    input  logic [7:0]          irq_raise_mask,
    output emb_pkg::entry_t     entry
);

    localparam logic [31:0] SIZE_A [emb_pkg::NUM_RGN] = '{
        32'(MAIN_BYTES), 32'(VIDEO_BYTES), 32'(AUDIO_BYTES),
        32'(EEPROM_BYTES), 32'(GPU_CMD_BYTES), 32'(IO_BYTES)
    };

    logic [31:0] base_reg [emb_pkg::NUM_RGN];
    logic [31:0] budget_reg;
    logic [31:0] version_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg[0] <= emb_pkg::MAIN_BASE_RST;
            base_reg[1] <= emb_pkg::VRAM_BASE_RST;
            base_reg[2] <= emb_pkg::AUDIO_BASE_RST;
            base_reg[3] <= emb_pkg::EEP_BASE_RST;
            base_reg[4] <= emb_pkg::GPU_BASE_RST;
            base_reg[5] <= emb_pkg::IO_BASE_RST;
            budget_reg  <= emb_pkg::BUDGET_RST;
            version_reg <= emb_pkg::VERSION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                emb_pkg::CFG_MAIN_BASE:  base_reg[0] <= cfg_data;
                emb_pkg::CFG_VRAM_BASE:  base_reg[1] <= cfg_data;
                emb_pkg::CFG_AUDIO_BASE: base_reg[2] <= cfg_data;
                emb_pkg::CFG_EEP_BASE:   base_reg[3] <= cfg_data;
                emb_pkg::CFG_GPU_BASE:   base_reg[4] <= cfg_data;
                emb_pkg::CFG_IO_BASE:    base_reg[5] <= cfg_data;
                emb_pkg::CFG_BUDGET:     budget_reg  <= cfg_data;
                emb_pkg::CFG_VERSION:    version_reg <= cfg_data;
                default:                 budget_reg  <= budget_reg;
            endcase
        end
    end

    logic [31:0] rgn_off  [emb_pkg::NUM_RGN];
    logic [31:0] rgn_left [emb_pkg::NUM_RGN];
    logic [emb_pkg::NUM_RGN-1:0] rgn_in;
    logic [emb_pkg::NUM_RGN-1:0] rgn_fit;
    logic [2:0]  nbytes;
    logic [31:0] io_off;
    logic        io_word;
    logic        found;
    logic [2:0]  sel;

    always_comb
    begin
        nbytes = 3'd1 << access_size;
        for (int r = 0; r < emb_pkg::NUM_RGN; r++)
        begin
            rgn_off[r]  = address - base_reg[r];
            rgn_left[r] = SIZE_A[r] - rgn_off[r];
            rgn_in[r]   = rgn_off[r] < SIZE_A[r];
            rgn_fit[r]  = rgn_left[r] >= {29'd0, nbytes};
        end
        // first matching region wins
        found = 1'b0;
        sel   = emb_pkg::RGN_MAIN;
        for (int r = emb_pkg::NUM_RGN - 1; r >= 0; r--)
        begin
            if (rgn_in[r])
            begin
                found = 1'b1;
                sel   = 3'(r);
            end
        end
        io_off  = address - base_reg[5];
        io_word = (access_size == emb_pkg::SZ_WORD) && (io_off < SIZE_A[5]);
    end

    always_comb
    begin
        entry        = '0;
        entry.kind   = emb_pkg::K_NOP;
        entry.size   = access_size;
        entry.region = sel;
        entry.off    = rgn_off[sel][emb_pkg::OFF_W-1:0];
        entry.data   = write_data;
        case (mode)
            emb_pkg::MODE_READ, emb_pkg::MODE_WRITE:
            begin
                if (access_size != emb_pkg::SZ_BAD)
                begin
                    if (found && rgn_fit[sel])
                        entry.kind = (mode == emb_pkg::MODE_READ) ? emb_pkg::K_MEM_RD
                                                                  : emb_pkg::K_MEM_WR;
                    // system registers win over any region
                    if (io_word && mode == emb_pkg::MODE_READ)
                    begin
                        if (io_off == emb_pkg::OFF_FRAME)
                            entry.kind = emb_pkg::K_REG_FRAME;
                        else if (io_off == emb_pkg::OFF_VERSION)
                        begin
                            entry.kind = emb_pkg::K_REG_VAL;
                            entry.data = version_reg;
                        end
                        else if (io_off == emb_pkg::OFF_MAIN_SZ)
                        begin
                            entry.kind = emb_pkg::K_REG_VAL;
                            entry.data = SIZE_A[0];
                        end
                        else if (io_off == emb_pkg::OFF_VIDEO_SZ)
                        begin
                            entry.kind = emb_pkg::K_REG_VAL;
                            entry.data = SIZE_A[1];
                        end
                        else if (io_off == emb_pkg::OFF_AUDIO_SZ)
                        begin
                            entry.kind = emb_pkg::K_REG_VAL;
                            entry.data = SIZE_A[2];
                        end
                        else if (io_off == emb_pkg::OFF_RANDOM)
                            entry.kind = emb_pkg::K_REG_RAND;
                        else if (io_off == emb_pkg::OFF_CYCLES)
                            entry.kind = emb_pkg::K_REG_CYC;
                        else if (io_off == emb_pkg::OFF_CYC_MAX)
                        begin
                            entry.kind = emb_pkg::K_REG_VAL;
                            entry.data = budget_reg;
                        end
                        else if (io_off == emb_pkg::OFF_IRQ_PEND)
                            entry.kind = emb_pkg::K_REG_IRQ;
                        else if (io_off == emb_pkg::OFF_IRQ_EN)
                        begin
                            // irq enable is a plain word of io store
                            entry.kind   = emb_pkg::K_MEM_RD;
                            entry.region = emb_pkg::RGN_IO;
                            entry.off    = io_off[emb_pkg::OFF_W-1:0];
                        end
                    end
                    else if (io_word && io_off == emb_pkg::OFF_IRQ_ACK)
                        entry.kind = emb_pkg::K_IRQ_ACK;
                end
            end
            emb_pkg::MODE_SET_FRAME:
            begin
                entry.kind = emb_pkg::K_SET_FRAME;
                entry.data = frame_value;
            end
            emb_pkg::MODE_SET_CYC:
            begin
                entry.kind = emb_pkg::K_SET_CYC;
                entry.data = cycles_value;
            end
            emb_pkg::MODE_IRQ_RAISE:
            begin
                entry.kind = emb_pkg::K_IRQ_RAISE;
                entry.data = {24'd0, irq_raise_mask};
            end
            default: entry.kind = emb_pkg::K_NOP;
        endcase
    end

endmodule

// ===== hdl/emb_queue.sv =====
// two-entry queue between front and back
module emb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  emb_pkg::entry_t    push_entry,
    input  logic               pop,
    output emb_pkg::entry_t    head,
    output emb_pkg::q_status_t status
);

    emb_pkg::entry_t slot_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

// ===== hdl/emb_store.sv =====
// byte store built from four byte-lane memories with registered read
module emb_store #(
    parameter int BYTES = emb_pkg::MAIN_BYTES_DEF
) (
    input  logic                                    clk,
    input  logic [emb_pkg::LANES-1:0][emb_pkg::ROW_AW-1:0] addr,
    input  logic [emb_pkg::LANES-1:0]               we,
    input  logic [emb_pkg::LANES-1:0][7:0]          wdata,
    output logic [emb_pkg::LANES-1:0][7:0]          rdata
);

    localparam int ROWS  = (BYTES + emb_pkg::LANES - 1) / emb_pkg::LANES;
    localparam int ROW_W = $clog2(ROWS);

    for (genvar k = 0; k < emb_pkg::LANES; k++)
    begin : g_lane
        logic [7:0] mem [ROWS];
        always_ff @(posedge clk)
        begin
            if (we[k])
                mem[addr[k][ROW_W-1:0]] <= wdata[k];
            rdata[k] <= mem[addr[k][ROW_W-1:0]];
        end
    end

endmodule

// ===== hdl/emb_back.sv =====
// back end: stores, system state, clearing pass and result register
module emb_back #(
    parameter int MAIN_BYTES    = emb_pkg::MAIN_BYTES_DEF,
    parameter int VIDEO_BYTES   = emb_pkg::VIDEO_BYTES_DEF,
    parameter int AUDIO_BYTES   = emb_pkg::AUDIO_BYTES_DEF,
    parameter int EEPROM_BYTES  = emb_pkg::EEPROM_BYTES_DEF,
    parameter int GPU_CMD_BYTES = emb_pkg::GPU_CMD_BYTES_DEF,
    parameter int IO_BYTES      = emb_pkg::IO_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  emb_pkg::entry_t    head,
    input  emb_pkg::q_status_t q_status,
    output logic               pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        read_data,
    output logic               hit,
    output logic [7:0]         irq_pending_now
);

    localparam int BYTES_A [emb_pkg::NUM_RGN] = '{
        MAIN_BYTES, VIDEO_BYTES, AUDIO_BYTES, EEPROM_BYTES, GPU_CMD_BYTES, IO_BYTES
    };

    function automatic int rows_of(input int b);
        return (b + emb_pkg::LANES - 1) / emb_pkg::LANES;
    endfunction

    function automatic int max_rows();
        int m;
        m = 0;
        for (int r = 0; r < emb_pkg::NUM_RGN; r++)
            if (rows_of(BYTES_A[r]) > m)
                m = rows_of(BYTES_A[r]);
        return m;
    endfunction

    localparam int MAX_ROWS = max_rows();

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [emb_pkg::ROW_AW-1:0]  clr_cnt_reg;
    emb_pkg::entry_t             cur_reg;
    logic [31:0]                 frame_reg, cycles_reg, seed_reg;
    logic [7:0]                  irq_reg, irq_next;
    logic [31:0]                 frame_next, cycles_next, seed_next;
    logic                        out_valid_reg;
    logic [31:0]                 out_data_reg;
    logic                        out_hit_reg;
    logic [7:0]                  out_irq_reg;
    logic                        out_taken;
    logic                        out_load;
    logic [31:0]                 res_data;
    logic                        res_hit;

    logic [emb_pkg::LANES-1:0][emb_pkg::ROW_AW-1:0] lane_addr;
    logic [emb_pkg::LANES-1:0][7:0]                 lane_wdata;
    logic [emb_pkg::LANES-1:0]                      lane_used;
    logic [emb_pkg::LANES-1:0][7:0]                 rd_lane [emb_pkg::NUM_RGN];
    logic [emb_pkg::LANES-1:0]                      st_we   [emb_pkg::NUM_RGN];
    logic [2:0]                                     nbytes;
    logic [1:0]                                     lane_idx [emb_pkg::LANES];
    logic [31:0]                                    asm_data;

    assign out_taken = out_valid_reg && !out_stall;
    assign pop       = (state_reg == ST_IDLE) && !q_status.empty
                       && (!out_valid_reg || !out_stall);
    assign clearing  = (state_reg == ST_CLEAR);
    assign nbytes    = 3'd1 << head.size;

    // lane k carries byte (k - off) mod 4 of the access
    always_comb
    begin
        for (int k = 0; k < emb_pkg::LANES; k++)
        begin
            lane_idx[k]  = 2'(k) - head.off[1:0];
            lane_used[k] = {1'b0, lane_idx[k]} < nbytes;
            if (clearing)
            begin
                lane_addr[k]  = clr_cnt_reg;
                lane_wdata[k] = 8'd0;
            end
            else
            begin
                lane_addr[k]  = head.off[emb_pkg::OFF_W-1:2]
                                + emb_pkg::ROW_AW'(2'(k) < head.off[1:0]);
                lane_wdata[k] = head.data[8*lane_idx[k] +: 8];
            end
        end
    end

    for (genvar r = 0; r < emb_pkg::NUM_RGN; r++)
    begin : g_store
        localparam int ROWS = rows_of(BYTES_A[r]);
        logic clr_ok;
        assign clr_ok = {1'b0, clr_cnt_reg} < (emb_pkg::ROW_AW + 1)'(ROWS);
        always_comb
        begin
            if (clearing)
                st_we[r] = {emb_pkg::LANES{clr_ok}};
            else if (pop && head.kind == emb_pkg::K_MEM_WR && head.region == 3'(r))
                st_we[r] = lane_used;
            else
                st_we[r] = '0;
        end
        emb_store #(.BYTES(BYTES_A[r])) u_store (
            .clk   (clk),
            .addr  (lane_addr),
            .we    (st_we[r]),
            .wdata (lane_wdata),
            .rdata (rd_lane[r])
        );
    end

    // reassemble the little-endian value from the lanes of the chosen store
    always_comb
    begin
        asm_data = 32'd0;
        for (int i = 0; i < emb_pkg::LANES; i++)
        begin
            if (3'(i) < (3'd1 << cur_reg.size))
                asm_data[8*i +: 8] = rd_lane[cur_reg.region][2'(i) + cur_reg.off[1:0]];
        end
    end

    always_comb
    begin
        frame_next  = frame_reg;
        cycles_next = cycles_reg;
        seed_next   = seed_reg;
        irq_next    = irq_reg;
        res_data    = 32'd0;
        res_hit     = 1'b0;
        state_next  = state_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == emb_pkg::ROW_AW'(MAX_ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    out_load = 1'b1;
                    res_hit  = 1'b1;
                    case (head.kind)
                        emb_pkg::K_MEM_RD:
                        begin
                            out_load   = 1'b0;
                            state_next = ST_READ;
                        end
                        emb_pkg::K_MEM_WR:    res_hit  = 1'b1;
                        emb_pkg::K_REG_VAL:   res_data = head.data;
                        emb_pkg::K_REG_FRAME: res_data = frame_reg;
                        emb_pkg::K_REG_RAND:
                        begin
                            seed_next = seed_reg * emb_pkg::LCG_MUL + emb_pkg::LCG_ADD;
                            res_data  = seed_next;
                        end
                        emb_pkg::K_REG_CYC:   res_data = cycles_reg;
                        emb_pkg::K_REG_IRQ:   res_data = {24'd0, irq_reg};
                        emb_pkg::K_IRQ_ACK:   irq_next = irq_reg & ~head.data[7:0];
                        emb_pkg::K_SET_FRAME:
                        begin
                            res_hit    = 1'b0;
                            frame_next = head.data;
                        end
                        emb_pkg::K_SET_CYC:
                        begin
                            res_hit     = 1'b0;
                            cycles_next = head.data;
                        end
                        emb_pkg::K_IRQ_RAISE:
                        begin
                            res_hit  = 1'b0;
                            irq_next = irq_reg | head.data[7:0];
                        end
                        default: res_hit = 1'b0;
                    endcase
                end
            end
            ST_READ:
            begin
                out_load   = 1'b1;
                res_hit    = 1'b1;
                res_data   = asm_data;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            frame_reg     <= 32'd0;
            cycles_reg    <= 32'd0;
            seed_reg      <= 32'd0;
            irq_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            frame_reg  <= frame_next;
            cycles_reg <= cycles_next;
            seed_reg   <= seed_next;
            irq_reg    <= irq_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + emb_pkg::ROW_AW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_taken)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (out_load)
        begin
            out_data_reg <= res_data;
            out_hit_reg  <= res_hit;
            out_irq_reg  <= irq_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = out_data_reg;
    assign hit             = out_hit_reg;
    assign irq_pending_now = out_irq_reg;

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop)
        else $error("queue popped during clearing pass");

    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == emb_pkg::K_MEM_RD) |=> (state_reg == ST_READ))
        else $error("memory read did not enter read state");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("result register busy when read data returns");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid_reg)
        else $error("result present during clearing pass");

endmodule

// ===== hdl/emulated_memory_bus_decoder.sv =====
// top level of the emulated memory bus decoder
// usage:
//   input channel (in_valid / in_stall) takes one bus word: mode, size,
//   address, write data and the housekeeping values. the user must write
//   configuration (cfg_we / cfg_index / cfg_data) while the block is idle;
//   the block does not enforce this. output channel (out_valid / out_stall)
//   returns one word per input word: read_data, hit and irq_pending_now.
// path: a word accepted passes through the queue into the result register;
//   a memory read also passes through the registered lane memories and the
//   read state before its data reaches the result register.
// throughput: one word per cycle for writes, register accesses and commands
//   while the receiver does not stall; a memory read holds the back end in
//   its read state, so the next word is not taken until its data returns.
// reset: all stores are swept to zero, one row of four bytes per cycle, over
//   ceil(largest region / 4) rows (16384 with default sizes); in_stall is
//   high during the sweep.
// when the receiver stalls, the result holds and the two-entry queue keeps
//   taking words until it fills, then in_stall rises.
module emulated_memory_bus_decoder #(
    parameter int MAIN_BYTES    = emb_pkg::MAIN_BYTES_DEF,
    parameter int VIDEO_BYTES   = emb_pkg::VIDEO_BYTES_DEF,
    parameter int AUDIO_BYTES   = emb_pkg::AUDIO_BYTES_DEF,
    parameter int EEPROM_BYTES  = emb_pkg::EEPROM_BYTES_DEF,
    parameter int GPU_CMD_BYTES = emb_pkg::GPU_CMD_BYTES_DEF,
    parameter int IO_BYTES      = emb_pkg::IO_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [1:0]  access_size,
    input  logic [31:0] address,
    input  logic [31:0] write_data,
    input  logic [31:0] frame_value,
    input  logic [31:0] cycles_value,
    input  logic [7:0]  irq_raise_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        hit,
    output logic [7:0]  irq_pending_now
);

    emb_pkg::entry_t    front_entry;
    emb_pkg::entry_t    q_head;
    emb_pkg::q_status_t q_status;
    logic               q_pop;
    logic               clearing;

    assign in_stall = q_status.full || clearing;

    emb_front #(
        .MAIN_BYTES(MAIN_BYTES), .VIDEO_BYTES(VIDEO_BYTES), .AUDIO_BYTES(AUDIO_BYTES),
        .EEPROM_BYTES(EEPROM_BYTES), .GPU_CMD_BYTES(GPU_CMD_BYTES), .IO_BYTES(IO_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .access_size    (access_size),
        .address        (address),
        .write_data     (write_data),
        .frame_value    (frame_value),
        .cycles_value   (cycles_value),
        .irq_raise_mask (irq_raise_mask),
        .entry          (front_entry)
    );

    emb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !in_stall),
        .push_entry (front_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    emb_back #(
        .MAIN_BYTES(MAIN_BYTES), .VIDEO_BYTES(VIDEO_BYTES), .AUDIO_BYTES(AUDIO_BYTES),
        .EEPROM_BYTES(EEPROM_BYTES), .GPU_CMD_BYTES(GPU_CMD_BYTES), .IO_BYTES(IO_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .q_status        (q_status),
        .pop             (q_pop),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .hit             (hit),
        .irq_pending_now (irq_pending_now)
    );

endmodule

// ===== test/emb_checker.sv =====
// checker for the emulated memory bus decoder: predicts each result word and compares
`timescale 1ns / 1ps

module emb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [1:0]  access_size,
    input  logic [31:0] address,
    input  logic [31:0] write_data,
    input  logic [31:0] frame_value,
    input  logic [31:0] cycles_value,
    input  logic [7:0]  irq_raise_mask,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] read_data,
    input  logic        hit,
    input  logic [7:0]  irq_pending_now,
    output int          mismatches,
    output int          waiting
);

    localparam int TOTAL_BYTES = emb_pkg::MAIN_BYTES_DEF + emb_pkg::VIDEO_BYTES_DEF
                               + emb_pkg::AUDIO_BYTES_DEF + emb_pkg::EEPROM_BYTES_DEF
                               + emb_pkg::GPU_CMD_BYTES_DEF + emb_pkg::IO_BYTES_DEF;

    typedef struct {
        logic [31:0] rd;
        logic        h;
        logic [7:0]  irq;
    } bus_result_t;

    // all six stores packed back to back in one byte array
    int          rgn_size [emb_pkg::NUM_RGN] = '{emb_pkg::MAIN_BYTES_DEF,
                                                 emb_pkg::VIDEO_BYTES_DEF,
                                                 emb_pkg::AUDIO_BYTES_DEF,
                                                 emb_pkg::EEPROM_BYTES_DEF,
                                                 emb_pkg::GPU_CMD_BYTES_DEF,
                                                 emb_pkg::IO_BYTES_DEF};
    int          rgn_start [emb_pkg::NUM_RGN];
    logic [7:0]  mem_bytes [TOTAL_BYTES];
    logic [31:0] bases [8];
    logic [31:0] frame_num;
    logic [31:0] cycle_count;
    logic [31:0] lcg_seed;
    logic [7:0]  irq_bits;
    bus_result_t expected_words [$];

    initial begin
        rgn_start[0] = 0;
        for (int r = 1; r < emb_pkg::NUM_RGN; r++)
            rgn_start[r] = rgn_start[r-1] + rgn_size[r-1];
        mismatches = 0;
        waiting = 0;
    end

    // first region whose window holds the address wins; -1 on a miss or when the access runs past that region's end
    function automatic int byte_index(input logic [31:0] a, input int n);
        logic [31:0] off;
        for (int r = 0; r < emb_pkg::NUM_RGN; r++)
        begin
            off = a - bases[r];
            if (off < rgn_size[r])
            begin
                if (rgn_size[r] - off < n)
                    return -1;
                return rgn_start[r] + int'(off);
            end
        end
        return -1;
    endfunction

    task automatic bus_access(output bus_result_t res);
        int          n;
        int          idx;
        logic [31:0] io_off;
        logic        done;
        res.rd = '0;
        res.h = 1'b0;
        done = 1'b0;
        if ((mode == emb_pkg::MODE_READ || mode == emb_pkg::MODE_WRITE)
            && access_size != emb_pkg::SZ_BAD)
        begin
            n = 1 << access_size;
            io_off = address - bases[emb_pkg::CFG_IO_BASE];
            if (n == 4 && io_off < emb_pkg::IO_BYTES_DEF)
            begin
                done = 1'b1;
                if (mode == emb_pkg::MODE_WRITE)
                begin
                    if (io_off == emb_pkg::OFF_IRQ_ACK)
                        irq_bits = irq_bits & ~write_data[7:0];
                    else
                        done = 1'b0;
                end
                else
                begin
                    case (io_off)
                        emb_pkg::OFF_FRAME:    res.rd = frame_num;
                        emb_pkg::OFF_VERSION:  res.rd = bases[emb_pkg::CFG_VERSION];
                        emb_pkg::OFF_MAIN_SZ:  res.rd = emb_pkg::MAIN_BYTES_DEF;
                        emb_pkg::OFF_VIDEO_SZ: res.rd = emb_pkg::VIDEO_BYTES_DEF;
                        emb_pkg::OFF_AUDIO_SZ: res.rd = emb_pkg::AUDIO_BYTES_DEF;
                        emb_pkg::OFF_RANDOM:
                        begin
                            lcg_seed = lcg_seed * emb_pkg::LCG_MUL + emb_pkg::LCG_ADD;
                            res.rd = lcg_seed;
                        end
                        emb_pkg::OFF_CYCLES:   res.rd = cycle_count;
                        emb_pkg::OFF_CYC_MAX:  res.rd = bases[emb_pkg::CFG_BUDGET];
                        emb_pkg::OFF_IRQ_PEND: res.rd = {24'd0, irq_bits};
                        emb_pkg::OFF_IRQ_EN:
                        begin
                            idx = rgn_start[emb_pkg::RGN_IO] + int'(io_off);
                            res.rd = {mem_bytes[idx+3], mem_bytes[idx+2],
                                      mem_bytes[idx+1], mem_bytes[idx]};
                        end
                        default: done = 1'b0;
                    endcase
                end
                res.h = done;
            end
            if (!done)
            begin
                idx = byte_index(address, n);
                if (idx >= 0)
                begin
                    res.h = 1'b1;
                    for (int i = 0; i < n; i++)
                    begin
                        if (mode == emb_pkg::MODE_READ)
                            res.rd[8*i +: 8] = mem_bytes[idx+i];
                        else
                            mem_bytes[idx+i] = write_data[8*i +: 8];
                    end
                end
            end
        end
        else if (mode == emb_pkg::MODE_SET_FRAME)
            frame_num = frame_value;
        else if (mode == emb_pkg::MODE_SET_CYC)
            cycle_count = cycles_value;
        else if (mode == emb_pkg::MODE_IRQ_RAISE)
            irq_bits = irq_bits | irq_raise_mask;
        res.irq = irq_bits;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t got;
        bus_result_t want;
        if (!rst_n)
        begin
            foreach (mem_bytes[i])
                mem_bytes[i] = 8'h00;
            bases[emb_pkg::CFG_MAIN_BASE]  = emb_pkg::MAIN_BASE_RST;
            bases[emb_pkg::CFG_VRAM_BASE]  = emb_pkg::VRAM_BASE_RST;
            bases[emb_pkg::CFG_AUDIO_BASE] = emb_pkg::AUDIO_BASE_RST;
            bases[emb_pkg::CFG_EEP_BASE]   = emb_pkg::EEP_BASE_RST;
            bases[emb_pkg::CFG_GPU_BASE]   = emb_pkg::GPU_BASE_RST;
            bases[emb_pkg::CFG_IO_BASE]    = emb_pkg::IO_BASE_RST;
            bases[emb_pkg::CFG_BUDGET]     = emb_pkg::BUDGET_RST;
            bases[emb_pkg::CFG_VERSION]    = emb_pkg::VERSION_RST;
            frame_num = '0;
            cycle_count = '0;
            lcg_seed = '0;
            irq_bits = '0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
                bases[cfg_index] = cfg_data;
            // a result can never leave in the cycle its word arrives, so check first
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (read_data !== want.rd)
                    begin
                        $error("read_data: expected %h, got %h", want.rd, read_data);
                        mismatches++;
                    end
                    if (hit !== want.h)
                    begin
                        $error("hit: expected %b, got %b", want.h, hit);
                        mismatches++;
                    end
                    if (irq_pending_now !== want.irq)
                    begin
                        $error("irq_pending_now: expected %h, got %h", want.irq,
                               irq_pending_now);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                bus_access(got);
                expected_words.push_back(got);
            end
        end
        waiting = expected_words.size();
    end

endmodule

// ===== test/tb_emulated_memory_bus_decoder.sv =====
// testbench top for the emulated memory bus decoder: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module tb_emulated_memory_bus_decoder;

    localparam logic [2:0] MODE_UNUSED = 3'd5;
    localparam logic [2:0] MODE_TOP    = 3'd7;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [2:0]  md;
        logic [1:0]  sz;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [31:0] frame;
        logic [31:0] cyc;
        logic [7:0]  mask;
    } bus_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [1:0]  access_size = '0;
    logic [31:0] address = '0;
    logic [31:0] write_data = '0;
    logic [31:0] frame_value = '0;
    logic [31:0] cycles_value = '0;
    logic [7:0]  irq_raise_mask = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic        hit;
    logic [7:0]  irq_pending_now;
    int          mismatches;
    int          waiting;

    logic [31:0] region_base [emb_pkg::NUM_RGN];
    int          region_size [emb_pkg::NUM_RGN] = '{emb_pkg::MAIN_BYTES_DEF,
                                                   emb_pkg::VIDEO_BYTES_DEF,
                                                   emb_pkg::AUDIO_BYTES_DEF,
                                                   emb_pkg::EEPROM_BYTES_DEF,
                                                   emb_pkg::GPU_CMD_BYTES_DEF,
                                                   emb_pkg::IO_BYTES_DEF};
    logic        calm = 1'b0;
    logic        squeeze = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;

    emulated_memory_bus_decoder dut (.*);

    emb_checker checker_i (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall after each taken word, plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (squeeze)
            begin
                squeeze = 1'b0;
                hold_left = 80;
            end
            else if (out_valid && !out_stall)
                hold_left = calm ? 0 : $urandom_range(0, 9);
            out_stall <= (hold_left > 0);
        end
    end

    task automatic send_word(input bus_word_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= w.md;
        access_size    <= w.sz;
        address        <= w.addr;
        write_data     <= w.wdata;
        frame_value    <= w.frame;
        cycles_value   <= w.cyc;
        irq_raise_mask <= w.mask;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // write enable stays high across a run of writes, cfg_done drops it
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx < emb_pkg::NUM_RGN)
            region_base[idx] = val;
    endtask

    task automatic cfg_done();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bus_word_t make_word(input logic [2:0] md, input logic [1:0] sz,
                                           input logic [31:0] addr,
                                           input logic [31:0] val);
        bus_word_t w;
        w.md = md;
        w.sz = sz;
        w.addr = addr;
        w.wdata = val;
        w.frame = val;
        w.cyc = val;
        w.mask = val[7:0];
        return w;
    endfunction

    function automatic logic [31:0] pick_address(output logic reg_like);
        int          r;
        int          k;
        logic [31:0] off;
        k = $urandom_range(0, 9);
        reg_like = 1'b0;
        if (k <= 5)
        begin
            r = $urandom_range(0, emb_pkg::NUM_RGN - 1);
            case ($urandom_range(0, 3))
                0: off = region_size[r] - $urandom_range(1, 5);
                1: off = $urandom_range(0, 7);
                2: off = $urandom_range(0, 63);
                default: off = $urandom_range(0, region_size[r] - 1);
            endcase
            return region_base[r] + off;
        end
        else if (k <= 7)
        begin
            reg_like = 1'b1;
            case ($urandom_range(0, 3))
                0: off = emb_pkg::OFF_FRAME;
                1: off = emb_pkg::OFF_VERSION + 4 * $urandom_range(0, 16);
                2: off = emb_pkg::OFF_IRQ_PEND + 4 * $urandom_range(0, 8);
                default: off = emb_pkg::OFF_RANDOM;
            endcase
            return region_base[emb_pkg::RGN_IO] + off;
        end
        else if (k == 8)
            return $urandom();
        return region_base[emb_pkg::RGN_IO] - $urandom_range(0, 3);
    endfunction

    function automatic bus_word_t random_word();
        bus_word_t w;
        logic      reg_like;
        int        m;
        w.addr  = pick_address(reg_like);
        w.wdata = $urandom();
        w.frame = $urandom();
        w.cyc   = $urandom();
        w.mask  = 8'($urandom_range(0, 255));
        m = $urandom_range(0, 99);
        if (m < 42)
            w.md = emb_pkg::MODE_READ;
        else if (m < 78)
            w.md = emb_pkg::MODE_WRITE;
        else if (m < 84)
            w.md = emb_pkg::MODE_SET_FRAME;
        else if (m < 90)
            w.md = emb_pkg::MODE_SET_CYC;
        else if (m < 96)
            w.md = emb_pkg::MODE_IRQ_RAISE;
        else
            w.md = 3'($urandom_range(MODE_UNUSED, MODE_TOP));
        if (reg_like && $urandom_range(0, 4) != 0)
            w.sz = emb_pkg::SZ_WORD;
        else
            w.sz = ($urandom_range(0, 19) == 0) ? emb_pkg::SZ_BAD
                                                 : 2'($urandom_range(0, 2));
        return w;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == count / 2)
                squeeze = 1'b1;
            send_word(random_word());
        end
        calm = 1'b0;
        drain();
    endtask

    task automatic directed_words();
        logic [31:0] io;
        logic [31:0] mb;
        io = region_base[emb_pkg::RGN_IO];
        mb = region_base[emb_pkg::RGN_MAIN];
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_VERSION, 0));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_MAIN_SZ, 0));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_VIDEO_SZ, 0));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_AUDIO_SZ, 0));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_RANDOM, 0));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_RANDOM, 0));
        send_word(make_word(emb_pkg::MODE_SET_FRAME, emb_pkg::SZ_BYTE, 0, 32'hFFFF_FFFF));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_FRAME, 0));
        send_word(make_word(emb_pkg::MODE_SET_CYC, emb_pkg::SZ_BYTE, 0, 32'hFFFF_FFFF));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_CYCLES, 0));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_CYC_MAX, 0));
        send_word(make_word(emb_pkg::MODE_IRQ_RAISE, emb_pkg::SZ_BYTE, 0, 32'hFF));
        send_word(make_word(emb_pkg::MODE_WRITE, emb_pkg::SZ_WORD, io + emb_pkg::OFF_IRQ_ACK,
                            32'hFFFF_FF0F));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_IRQ_PEND, 0));
        // enable register is plain store bytes
        send_word(make_word(emb_pkg::MODE_WRITE, emb_pkg::SZ_WORD, io + emb_pkg::OFF_IRQ_EN,
                            32'hA5C3_1E77));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, io + emb_pkg::OFF_IRQ_EN, 0));
        // a write to a read-only register lands in the store
        send_word(make_word(emb_pkg::MODE_WRITE, emb_pkg::SZ_WORD, io + emb_pkg::OFF_VERSION,
                            32'h1234_5678));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_HALF, io + emb_pkg::OFF_VERSION + 2,
                            0));
        send_word(make_word(emb_pkg::MODE_WRITE, emb_pkg::SZ_BYTE, mb + 16'hFFFF, 32'hEE));
        send_word(make_word(emb_pkg::MODE_WRITE, emb_pkg::SZ_HALF, mb + 16'hFFFF, 32'hBBAA));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_WORD, mb + 16'hFFFC, 0));
        send_word(make_word(MODE_UNUSED, emb_pkg::SZ_WORD, io + emb_pkg::OFF_VERSION,
                            32'hFFFF_FFFF));
        send_word(make_word(MODE_TOP, emb_pkg::SZ_BYTE, 0, 32'hFFFF_FFFF));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_BAD, mb, 0));
        send_word(make_word(emb_pkg::MODE_READ, emb_pkg::SZ_BYTE, 32'hFFFF_FFFF, 0));
        drain();
    endtask

    initial
    begin
        region_base[emb_pkg::RGN_MAIN]  = emb_pkg::MAIN_BASE_RST;
        region_base[emb_pkg::RGN_VIDEO] = emb_pkg::VRAM_BASE_RST;
        region_base[emb_pkg::RGN_AUDIO] = emb_pkg::AUDIO_BASE_RST;
        region_base[emb_pkg::RGN_EEP]   = emb_pkg::EEP_BASE_RST;
        region_base[emb_pkg::RGN_GPU]   = emb_pkg::GPU_BASE_RST;
        region_base[emb_pkg::RGN_IO]    = emb_pkg::IO_BASE_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        random_phase(400);

        // overlapping and wrapping windows, main sits on top of the io window
        set_reg(emb_pkg::CFG_MAIN_BASE, 32'h1000_0000);
        set_reg(emb_pkg::CFG_VRAM_BASE, 32'hFFFF_FF00);
        set_reg(emb_pkg::CFG_AUDIO_BASE, 32'hFFFF_FFFF);
        set_reg(emb_pkg::CFG_EEP_BASE, 32'h0000_0000);
        set_reg(emb_pkg::CFG_GPU_BASE, 32'h0001_0000);
        set_reg(emb_pkg::CFG_IO_BASE, 32'h1000_0000);
        set_reg(emb_pkg::CFG_BUDGET, 32'hFFFF_FFFF);
        set_reg(emb_pkg::CFG_VERSION, 32'hFFFF_FFFF);
        cfg_done();
        directed_words();
        random_phase(400);

        // io window wraps past the top of the address space
        set_reg(emb_pkg::CFG_MAIN_BASE, 32'h1234_5678);
        set_reg(emb_pkg::CFG_VRAM_BASE, 32'h4000_0000);
        set_reg(emb_pkg::CFG_AUDIO_BASE, 32'h5000_0000);
        set_reg(emb_pkg::CFG_EEP_BASE, 32'h6000_0000);
        set_reg(emb_pkg::CFG_GPU_BASE, 32'h7000_0000);
        set_reg(emb_pkg::CFG_IO_BASE, 32'hFFFF_F800);
        set_reg(emb_pkg::CFG_BUDGET, 32'h0000_0000);
        set_reg(emb_pkg::CFG_VERSION, 32'h0000_0000);
        cfg_done();
        random_phase(420);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/emb_pkg.sv
hdl/emb_front.sv
hdl/emb_queue.sv
hdl/emb_store.sv
hdl/emb_back.sv
hdl/emulated_memory_bus_decoder.sv
test/emb_checker.sv
test/tb_emulated_memory_bus_decoder.sv
